/* src/mfhf_pkg.sv */
package mfhf_pkg;

  // byte_role codes
  localparam logic [1:0] ROLE_TYPE    = 2'd0;
  localparam logic [1:0] ROLE_LEN     = 2'd1;
  localparam logic [1:0] ROLE_BODY    = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  // status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_KNOWN   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_STATS   = 3'd3;
  localparam logic [2:0] ST_CLOSED  = 3'd4;

  // MQTT packet types classed as known
  localparam logic [3:0] PT_CONNECT     = 4'd1;
  localparam logic [3:0] PT_PUBLISH     = 4'd3;
  localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] PT_PINGREQ     = 4'd12;
  localparam logic [3:0] PT_DISCONNECT  = 4'd14;

  // register map: word index decoded from paddr[2]
  localparam logic REG_MAX_FRAME = 1'b0;
  localparam logic [15:0] MAX_FRAME_RESET = 16'd2048;

  localparam logic [28:0] HEADER_SLACK = 29'd5;
  localparam logic [7:0]  STATS_FIRST  = 8'h73;  // 's'
  localparam logic [7:0]  STATS_SECOND = 8'h74;  // 't'

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [1:0]  byte_role;
    logic [3:0]  packet_type;
    logic [27:0] remaining_length;
    logic        frame_end;
    logic [2:0]  status;
  } result_t;

endpackage

/* src/mfhf_ifs.sv */
interface mfhf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface mfhf_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [1:0]  byte_role;
  logic [3:0]  packet_type;
  logic [27:0] remaining_length;
  logic        frame_end;
  logic [2:0]  status;
  modport source (output valid, output byte_value, output byte_role, output packet_type,
                  output remaining_length, output frame_end, output status, input ready);
  modport sink   (input valid, input byte_value, input byte_role, input packet_type,
                  input remaining_length, input frame_end, input status, output ready);
endinterface

/* src/mfhf_cfg.sv */
module mfhf_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_frame_bytes
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == mfhf_pkg::REG_MAX_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= mfhf_pkg::MAX_FRAME_RESET;
    end else if (wr_en) begin
      max_frame_bytes <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == mfhf_pkg::REG_MAX_FRAME) begin
      prdata = {16'd0, max_frame_bytes};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

/* src/mfhf_core.sv */
module mfhf_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           max_frame_bytes,
  output mfhf_pkg::result_t     res
);

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_BODY,
    PH_CLOSED
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [27:0] len_acc, len_acc_next;
  logic [1:0]  len_idx, len_idx_next;
  logic [27:0] body_rem, body_rem_next;

  logic [27:0] acc_c;
  logic [1:0]  idx_c;
  logic        do_len;
  logic [27:0] group_shifted;
  logic [27:0] rem_dec;
  logic        oversize;

  function automatic logic [2:0] class_of(input logic [3:0] ptype);
    logic [2:0] st;
    case (ptype)
      mfhf_pkg::PT_CONNECT, mfhf_pkg::PT_PUBLISH, mfhf_pkg::PT_SUBSCRIBE,
      mfhf_pkg::PT_UNSUBSCRIBE, mfhf_pkg::PT_PINGREQ, mfhf_pkg::PT_DISCONNECT:
        st = mfhf_pkg::ST_KNOWN;
      default:
        st = mfhf_pkg::ST_UNKNOWN;
    endcase
    return st;
  endfunction

  // 7-bit group placed at its weight for the incoming length byte
  always_comb begin
    case (len_idx + 2'd1)
      2'd1:    group_shifted = {14'd0, data_byte[6:0], 7'd0};
      2'd2:    group_shifted = {7'd0, data_byte[6:0], 14'd0};
      2'd3:    group_shifted = {data_byte[6:0], 21'd0};
      default: group_shifted = {21'd0, data_byte[6:0]};
    endcase
  end

  assign rem_dec = (body_rem != 28'd0) ? body_rem - 28'd1 : body_rem;

  always_comb begin
    phase_next      = phase;
    first_byte_next = first_byte;
    len_acc_next    = len_acc;
    len_idx_next    = len_idx;
    body_rem_next   = body_rem;
    acc_c           = len_acc;
    idx_c           = len_idx;
    do_len          = 1'b0;
    oversize        = 1'b0;

    res.byte_value       = data_byte;
    res.byte_role        = mfhf_pkg::ROLE_IGNORED;
    res.packet_type      = 4'd0;
    res.remaining_length = 28'd0;
    res.frame_end        = 1'b0;
    res.status           = mfhf_pkg::ST_BUSY;

    case (phase)
      PH_TYPE: begin
        first_byte_next = data_byte;
        len_acc_next    = 28'd0;
        len_idx_next    = 2'd0;
        body_rem_next   = 28'd0;
        phase_next      = PH_LEN_FIRST;
        res.byte_role   = mfhf_pkg::ROLE_TYPE;
        res.packet_type = data_byte[7:4];
      end
      PH_LEN_FIRST: begin
        res.packet_type = first_byte[7:4];
        if (first_byte == mfhf_pkg::STATS_FIRST && data_byte == mfhf_pkg::STATS_SECOND) begin
          res.byte_role = mfhf_pkg::ROLE_BODY;
          res.frame_end = 1'b1;
          res.status    = mfhf_pkg::ST_STATS;
          phase_next    = PH_TYPE;
        end else begin
          res.byte_role = mfhf_pkg::ROLE_LEN;
          acc_c         = {21'd0, data_byte[6:0]};
          idx_c         = 2'd0;
          do_len        = 1'b1;
        end
      end
      PH_LEN_MORE: begin
        res.packet_type = first_byte[7:4];
        res.byte_role   = mfhf_pkg::ROLE_LEN;
        if (len_idx == 2'd3) begin
          // fifth length byte
          phase_next           = PH_CLOSED;
          res.frame_end        = 1'b1;
          res.status           = mfhf_pkg::ST_CLOSED;
          res.remaining_length = len_acc;
        end else begin
          idx_c  = len_idx + 2'd1;
          acc_c  = len_acc + group_shifted;
          do_len = 1'b1;
        end
      end
      PH_BODY: begin
        res.packet_type      = first_byte[7:4];
        res.byte_role        = mfhf_pkg::ROLE_BODY;
        res.remaining_length = len_acc;
        body_rem_next        = rem_dec;
        if (rem_dec == 28'd0) begin
          res.frame_end = 1'b1;
          res.status    = class_of(first_byte[7:4]);
          phase_next    = PH_TYPE;
        end
      end
      default: begin
        phase_next = PH_CLOSED;
      end
    endcase

    // common tail of every length byte: oversize check, then route
    if (do_len) begin
      len_acc_next         = acc_c;
      len_idx_next         = idx_c;
      res.remaining_length = acc_c;
      oversize = ({1'b0, acc_c} + mfhf_pkg::HEADER_SLACK) > {13'd0, max_frame_bytes};
      if (oversize) begin
        phase_next    = PH_CLOSED;
        res.frame_end = 1'b1;
        res.status    = mfhf_pkg::ST_CLOSED;
      end else if (data_byte[7]) begin
        phase_next = PH_LEN_MORE;
      end else if (acc_c == 28'd0) begin
        phase_next    = PH_TYPE;
        res.frame_end = 1'b1;
        res.status    = class_of(first_byte[7:4]);
      end else begin
        body_rem_next = acc_c;
        phase_next    = PH_BODY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      first_byte <= 8'd0;
      len_acc    <= 28'd0;
      len_idx    <= 2'd0;
      body_rem   <= 28'd0;
    end else if (adv) begin
      phase      <= phase_next;
      first_byte <= first_byte_next;
      len_acc    <= len_acc_next;
      len_idx    <= len_idx_next;
      body_rem   <= body_rem_next;
    end
  end

  // a closing result leaves the framer closed
  a_close_sticks: assert property (@(posedge clk) disable iff (rst)
    adv && res.status == mfhf_pkg::ST_CLOSED |=> phase == PH_CLOSED)
    else $error("closing result did not close the framer");

  // once closed, every later byte is ignored
  a_closed_ignores: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CLOSED |-> res.byte_role == mfhf_pkg::ROLE_IGNORED && !res.frame_end)
    else $error("byte classified after close");

  // body is only entered with a nonzero byte count
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    adv && phase != PH_BODY && phase_next == PH_BODY |=> body_rem != 28'd0)
    else $error("body entered with zero count");

endmodule

/* src/mqtt_fixed_header_framer.sv */
// MQTT fixed-header framer. Accepts one received byte per transaction on rx
// and returns exactly one result transaction on tx per byte, in order: the
// byte itself, its role (type, length, body, or ignored after close), the
// frame's packet type, the remaining length decoded so far, a frame-end flag
// and a status (known/unknown type, stats request 's''t', or closed).
// Sustained rate is one byte per clock without tx back-pressure; the
// per-byte decode is a single combinational pass over the framer state. A
// result passes the input register and then the result register before it
// goes valid on tx; both stages stall cleanly under tx back-pressure.
// max_frame_bytes (APB word 0, reset 2048) sets the oversize limit: length
// + 5 above it closes the connection until reset.
// Write it only while no bytes are in flight.
module mqtt_fixed_header_framer (
  input  logic                 clk,
  input  logic                 rst,
  mfhf_byte_if.sink            rx,
  mfhf_result_if.source        tx,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               out_free;
  logic               s1_adv;
  logic [15:0]        max_frame_bytes;
  mfhf_pkg::result_t  step_res;
  mfhf_pkg::result_t  res_q;

  mfhf_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_frame_bytes (max_frame_bytes)
  );

  // result register can load when empty or being drained this cycle
  assign out_free = !tx.valid || tx.ready;
  assign s1_adv   = s1_valid && out_free;
  assign rx.ready = !s1_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.data_byte;
    end
  end

  // framer state and per-byte decode
  mfhf_core u_core (
    .clk             (clk),
    .rst             (rst),
    .adv             (s1_adv),
    .data_byte       (s1_byte),
    .max_frame_bytes (max_frame_bytes),
    .res             (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (out_free) begin
      tx.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_q <= step_res;
    end
  end

  assign tx.byte_value       = res_q.byte_value;
  assign tx.byte_role        = res_q.byte_role;
  assign tx.packet_type      = res_q.packet_type;
  assign tx.remaining_length = res_q.remaining_length;
  assign tx.frame_end        = res_q.frame_end;
  assign tx.status           = res_q.status;

  // every advanced byte shows up as a result next cycle
  a_adv_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> tx.valid)
    else $error("decoded byte lost before result register");

  // a stalled result keeps the input stage from advancing
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    tx.valid && !tx.ready |-> !s1_adv)
    else $error("input stage advanced over a stalled result");

  // frame end always carries a final status
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.frame_end |-> tx.status != mfhf_pkg::ST_BUSY)
    else $error("frame end without status");

endmodule

/* tb/mqtt_fixed_header_framer_tb.sv */
module mqtt_fixed_header_framer_tb;

  localparam int IDLE_PCT     = 19;    // per-cycle idle odds on either side
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction at all
  localparam int HOLD_PHASE   = 3;     // limit setting during which the long hold-off runs
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 220;   // random bytes per limit setting
  localparam int N_PHASES     = 8;
  localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin

  localparam logic [2:0] MAX_FRAME_ADDR = {mfhf_pkg::REG_MAX_FRAME, 2'b00};

  typedef enum logic [2:0] {
    WAIT_TYPE, LEN_FIRST, LEN_MORE, IN_BODY, SHUT
  } frame_phase_e;

  typedef struct packed {
    frame_phase_e ph;
    logic [7:0]   first;  // type byte of the current frame
    logic [27:0]  acc;    // remaining length decoded so far
    logic [1:0]   idx;    // length bytes seen minus one
    logic [27:0]  left;   // body bytes still to come
  } framer_state_t;

  typedef enum logic [1:0] {
    CLOSE_OVERSIZE_FIRST, CLOSE_OVERSIZE_LATE, CLOSE_FIFTH_LEN
  } close_kind_e;

  typedef struct {
    logic [7:0]        b;
    bit                typed;   // expectation written out by hand
    mfhf_pkg::result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mfhf_byte_if   rx_if ();
  mfhf_result_if tx_if ();

  mqtt_fixed_header_framer u_dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .tx      (tx_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow framer state, advanced once per accepted byte
  framer_state_t     model;
  logic [15:0]       limit_now;
  mfhf_pkg::result_t pending_results[$];
  dir_row_t          directed[$];

  bit          calm;           // no idling on either side while set
  bit          hold_done;
  int          phase_now;
  int          fails;
  int          bytes_sent;
  int          frames_ended;
  int          stats_seen;
  int          results_seen;
  int          hold_left;
  int          quiet_cycles;
  close_kind_e close_how;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------
  function automatic logic [2:0] type_class(input logic [3:0] t);
    case (t)
      mfhf_pkg::PT_CONNECT, mfhf_pkg::PT_PUBLISH, mfhf_pkg::PT_SUBSCRIBE,
      mfhf_pkg::PT_UNSUBSCRIBE, mfhf_pkg::PT_PINGREQ, mfhf_pkg::PT_DISCONNECT:
        return mfhf_pkg::ST_KNOWN;
      default:
        return mfhf_pkg::ST_UNKNOWN;
    endcase
  endfunction

  // Oversize check runs after every length byte; then either more length,
  // a zero-length frame end, or the body.
  function automatic void length_byte_done(inout framer_state_t s, input logic [15:0] limit,
                                           input logic more, inout mfhf_pkg::result_t r);
    if (({1'b0, s.acc} + mfhf_pkg::HEADER_SLACK) > {13'd0, limit}) begin
      s.ph        = SHUT;
      r.frame_end = 1'b1;
      r.status    = mfhf_pkg::ST_CLOSED;
    end else if (more) begin
      s.ph = LEN_MORE;
    end else if (s.acc == 28'd0) begin
      s.ph        = WAIT_TYPE;
      r.frame_end = 1'b1;
      r.status    = type_class(s.first[7:4]);
    end else begin
      s.left = s.acc;
      s.ph   = IN_BODY;
    end
  endfunction

  function automatic mfhf_pkg::result_t frame_step(inout framer_state_t s,
                                                   input logic [15:0] limit,
                                                   input logic [7:0] b);
    mfhf_pkg::result_t r;
    r            = '0;
    r.byte_value = b;
    r.byte_role  = mfhf_pkg::ROLE_IGNORED;
    r.status     = mfhf_pkg::ST_BUSY;
    case (s.ph)
      WAIT_TYPE: begin
        s.first       = b;
        s.acc         = '0;
        s.idx         = '0;
        s.left        = '0;
        s.ph          = LEN_FIRST;
        r.byte_role   = mfhf_pkg::ROLE_TYPE;
        r.packet_type = b[7:4];
      end
      LEN_FIRST: begin
        r.packet_type = s.first[7:4];
        if (s.first == mfhf_pkg::STATS_FIRST && b == mfhf_pkg::STATS_SECOND) begin
          r.byte_role = mfhf_pkg::ROLE_BODY;
          r.frame_end = 1'b1;
          r.status    = mfhf_pkg::ST_STATS;
          s.ph        = WAIT_TYPE;
        end else begin
          r.byte_role = mfhf_pkg::ROLE_LEN;
          s.acc       = 28'(b[6:0]);
          s.idx       = '0;
          length_byte_done(s, limit, b[7], r);
          r.remaining_length = s.acc;
        end
      end
      LEN_MORE: begin
        r.packet_type = s.first[7:4];
        r.byte_role   = mfhf_pkg::ROLE_LEN;
        if (s.idx == 2'd3) begin
          // four length bytes all had the continuation bit
          s.ph        = SHUT;
          r.frame_end = 1'b1;
          r.status    = mfhf_pkg::ST_CLOSED;
        end else begin
          s.idx = s.idx + 2'd1;
          s.acc = s.acc + (28'(b[6:0]) << (7 * s.idx));
          length_byte_done(s, limit, b[7], r);
        end
        r.remaining_length = s.acc;
      end
      IN_BODY: begin
        r.packet_type      = s.first[7:4];
        r.byte_role        = mfhf_pkg::ROLE_BODY;
        r.remaining_length = s.acc;
        if (s.left != 28'd0) s.left = s.left - 28'd1;
        if (s.left == 28'd0) begin
          r.frame_end = 1'b1;
          r.status    = type_class(s.first[7:4]);
          s.ph        = WAIT_TYPE;
        end
      end
      default: begin
        s.ph = SHUT;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------
  function automatic void add_row(input logic [7:0] b);
    dir_row_t row;
    row.b     = b;
    row.typed = 1'b0;
    row.want  = '0;
    directed.push_back(row);
  endfunction

  function automatic void add_row_exp(input logic [7:0] b, input logic [1:0] role,
                                      input logic [3:0] pt, input logic [27:0] len,
                                      input logic fe, input logic [2:0] st);
    dir_row_t row;
    row.b     = b;
    row.typed = 1'b1;
    row.want  = {b, role, pt, len, fe, st};
    directed.push_back(row);
  endfunction

  // ---------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------
  // guarded: a byte that would close the connection (or leave a fourth
  // length byte with its continuation bit set) is replaced by zero, which
  // always ends the length field safely.
  task automatic send_byte(input logic [7:0] b, input bit guarded, input bit typed,
                           input mfhf_pkg::result_t want);
    framer_state_t     trial;
    mfhf_pkg::result_t r;
    if (guarded) begin
      trial = model;
      r     = frame_step(trial, limit_now, b);
      if (r.status == mfhf_pkg::ST_CLOSED || (trial.ph == LEN_MORE && trial.idx == 2'd3))
        b = 8'h00;
    end
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.data_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    // transaction taken at this edge
    r = frame_step(model, limit_now, b);
    pending_results.push_back(typed ? want : r);
    bytes_sent++;
    if (r.frame_end) frames_ended++;
    if (r.status == mfhf_pkg::ST_STATS) stats_seen++;
  endtask

  // One frame with random content; now and then preceded by junk or cut short.
  task automatic send_frame();
    logic [7:0]  q[$];
    logic [7:0]  lead;
    logic [7:0]  grp;
    logic [27:0] v;
    int          cap;
    int          len;
    int          n_len;
    int          n_pad;
    int          cut;
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b1, 1'b0, '0);
    case ($urandom_range(7))
      0: lead = mfhf_pkg::STATS_FIRST;
      1: lead = 8'($urandom);
      default: begin
        case ($urandom_range(5))
          0: lead = {mfhf_pkg::PT_CONNECT, 4'($urandom)};
          1: lead = {mfhf_pkg::PT_PUBLISH, 4'($urandom)};
          2: lead = {mfhf_pkg::PT_SUBSCRIBE, 4'($urandom)};
          3: lead = {mfhf_pkg::PT_UNSUBSCRIBE, 4'($urandom)};
          4: lead = {mfhf_pkg::PT_PINGREQ, 4'($urandom)};
          default: lead = {mfhf_pkg::PT_DISCONNECT, 4'($urandom)};
        endcase
      end
    endcase
    q.push_back(lead);
    if (lead == mfhf_pkg::STATS_FIRST && $urandom_range(9) < 6) begin
      q.push_back(mfhf_pkg::STATS_SECOND);
    end else begin
      // keep length + header slack within the limit; mostly short bodies
      cap = int'(limit_now) - 5;
      case ($urandom_range(9))
        0:       len = (cap <= 400) ? cap : $urandom_range(400, 128);
        1, 2:    len = $urandom_range((cap < 200) ? cap : 200, 0);
        default: len = $urandom_range((cap < 12) ? cap : 12, 0);
      endcase
      v     = 28'(len);
      n_len = 0;
      do begin
        grp = {1'b0, v[6:0]};
        v   = v >> 7;
        if (v != 28'd0) grp[7] = 1'b1;
        q.push_back(grp);
        n_len++;
      end while (v != 28'd0);
      // non-minimal encoding: trailing zero groups, four length bytes at most
      n_pad = ($urandom_range(3) == 0) ? $urandom_range(4 - n_len) : 0;
      if (n_pad > 0) begin
        q[q.size() - 1] = q[q.size() - 1] | 8'h80;
        repeat (n_pad - 1) q.push_back(8'h80);
        q.push_back(8'h00);
      end
      repeat (len) q.push_back(8'($urandom));
    end
    cut = ($urandom_range(99) < 8) ? $urandom_range(q.size() - 1) : q.size();
    for (int i = 0; i < cut; i++) send_byte(q[i], 1'b1, 1'b0, '0);
  endtask

  // bring the framer back to a frame boundary
  task automatic finish_frame();
    while (model.ph != WAIT_TYPE)
      send_byte((model.ph == IN_BODY) ? 8'($urandom) : 8'h00, 1'b1, 1'b0, '0);
  endtask

  // stop offering, let every result come back, let the pipe go quiet
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // optional APB write of max_frame_bytes, then a read-back check
  task automatic set_limit(input logic [15:0] v, input bit do_write);
    logic [15:0] got;
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MAX_FRAME_ADDR;
      pwdata  <= {16'd0, v};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      limit_now = v;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_FRAME_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== v) begin
      $display("%0t: max_frame_bytes read expected %0d got %0d", $time, v, got);
      fails++;
    end
  endtask

  task automatic check_field(input string name, input logic [27:0] want,
                             input logic [27:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      fails++;
    end
  endtask

  // ---------------------------------------------------------------
  // Result side: ready pattern, long hold-off, field-by-field check
  // ---------------------------------------------------------------
  always @(posedge clk) begin : result_side
    mfhf_pkg::result_t got;
    mfhf_pkg::result_t want;
    if (rst) begin
      tx_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        got = {tx_if.byte_value, tx_if.byte_role, tx_if.packet_type,
               tx_if.remaining_length, tx_if.frame_end, tx_if.status};
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result expected none got 0x%0h", $time, got);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("byte_value", 28'(want.byte_value), 28'(got.byte_value));
          check_field("byte_role", 28'(want.byte_role), 28'(got.byte_role));
          check_field("packet_type", 28'(want.packet_type), 28'(got.packet_type));
          check_field("remaining_length", want.remaining_length, got.remaining_length);
          check_field("frame_end", 28'(want.frame_end), 28'(got.frame_end));
          check_field("status", 28'(want.status), 28'(got.status));
        end
      end
      // long back-pressure at the start of one limit setting: the sender
      // keeps offering, so the pipe fills
      if (!hold_done && phase_now == HOLD_PHASE) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_if.ready <= 1'b0;
      end else begin
        tx_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    logic [15:0] limits[N_PHASES];
    int          n0;
    clk             = 1'b0;
    rst             <= 1'b1;
    rx_if.valid     <= 1'b0;
    rx_if.data_byte <= 8'h00;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    calm         = 1'b0;
    phase_now    = -1;
    fails        = 0;
    bytes_sent   = 0;
    frames_ended = 0;
    stats_seen   = 0;
    results_seen = 0;
    model        = '0;
    model.ph     = WAIT_TYPE;
    limit_now    = mfhf_pkg::MAX_FRAME_RESET;

    // limit settings, extremes included; the last one large for the late close
    limits[0] = 16'd8;
    limits[1] = 16'd65535;
    limits[2] = 16'd9;
    limits[3] = 16'($urandom_range(2000, 10));
    limits[4] = 16'd300;
    limits[5] = 16'd133;
    limits[6] = 16'($urandom_range(65535, 8));
    limits[7] = 16'd65535;

    // hand-written frames at the reset limit
    add_row_exp(8'h30, mfhf_pkg::ROLE_TYPE,
                mfhf_pkg::PT_PUBLISH, 28'd0, 1'b0, mfhf_pkg::ST_BUSY);
    add_row(8'h02);
    add_row(8'h00);
    add_row_exp(8'hFF, mfhf_pkg::ROLE_BODY,
                mfhf_pkg::PT_PUBLISH, 28'd2, 1'b1, mfhf_pkg::ST_KNOWN);
    add_row_exp(8'hC0, mfhf_pkg::ROLE_TYPE,
                mfhf_pkg::PT_PINGREQ, 28'd0, 1'b0, mfhf_pkg::ST_BUSY);
    add_row_exp(8'h00, mfhf_pkg::ROLE_LEN,                              // zero length
                mfhf_pkg::PT_PINGREQ, 28'd0, 1'b1, mfhf_pkg::ST_KNOWN);
    add_row(mfhf_pkg::STATS_FIRST);
    add_row_exp(mfhf_pkg::STATS_SECOND, mfhf_pkg::ROLE_BODY,            // stats request
                4'd7, 28'd0, 1'b1, mfhf_pkg::ST_STATS);
    add_row(mfhf_pkg::STATS_FIRST);                                     // 's' then a length
    add_row(8'h01);
    add_row_exp(8'h55, mfhf_pkg::ROLE_BODY, 4'd7, 28'd1, 1'b1, mfhf_pkg::ST_UNKNOWN);
    add_row_exp(8'h00, mfhf_pkg::ROLE_TYPE, 4'd0, 28'd0, 1'b0, mfhf_pkg::ST_BUSY);
    add_row(8'h80);                                                     // padded zero length
    add_row_exp(8'h00, mfhf_pkg::ROLE_LEN, 4'd0, 28'd0, 1'b1, mfhf_pkg::ST_UNKNOWN);
    add_row(8'hF0);
    add_row(8'h81);                                                     // four length bytes
    add_row(8'h80);
    add_row(8'h80);
    add_row(8'h00);
    add_row_exp(8'hAA, mfhf_pkg::ROLE_BODY, 4'd15, 28'd1, 1'b1, mfhf_pkg::ST_UNKNOWN);
    add_row(8'h8F);
    add_row_exp(8'h00, mfhf_pkg::ROLE_LEN,
                mfhf_pkg::PT_SUBSCRIBE, 28'd0, 1'b1, mfhf_pkg::ST_KNOWN);
    add_row(8'hE0);
    add_row_exp(8'h00, mfhf_pkg::ROLE_LEN,
                mfhf_pkg::PT_DISCONNECT, 28'd0, 1'b1, mfhf_pkg::ST_KNOWN);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_limit(mfhf_pkg::MAX_FRAME_RESET, 1'b0);   // reset value reads back

    foreach (directed[i]) send_byte(directed[i].b, 1'b0, directed[i].typed, directed[i].want);

    // random frames under each limit; register written only with the pipe empty
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      set_limit(limits[p], 1'b1);
      calm      = (p == 4);
      phase_now = p;
      n0        = bytes_sent;
      while (bytes_sent - n0 < PHASE_BYTES) send_frame();
      finish_frame();
    end
    calm = 1'b0;

    // close the connection one way, then feed bytes that must be ignored
    settle();
    close_how = close_kind_e'($urandom_range(2));
    case (close_how)
      CLOSE_OVERSIZE_FIRST: begin
        set_limit(16'd8, 1'b1);
        send_byte(8'h20, 1'b0, 1'b0, '0);
        send_byte(8'h04, 1'b0, 1'b0, '0);   // 4 + 5 > 8
      end
      CLOSE_OVERSIZE_LATE: begin
        send_byte(8'h30, 1'b0, 1'b0, '0);
        send_byte(8'hFF, 1'b0, 1'b0, '0);
        send_byte(8'hFF, 1'b0, 1'b0, '0);
        send_byte(8'h7F, 1'b0, 1'b0, '0);
      end
      default: begin
        send_byte(8'h30, 1'b0, 1'b0, '0);
        repeat (4) send_byte(8'h80, 1'b0, 1'b0, '0);
        send_byte(8'h5A, 1'b0, 1'b0, '0);   // fifth length byte
      end
    endcase
    repeat (12) send_byte(8'($urandom), 1'b0, 1'b0, '0);

    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes over %0d limit settings: %0d frame ends, %0d stats requests",
             bytes_sent, N_PHASES + 1, frames_ended, stats_seen);
    $display("connection finally closed by %s, %0d mismatches", close_how.name(), fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
